// ===== hdl/fcca_pkg.sv =====
// Shared operation codes, status codes and fixed field widths of the cluster chain allocator.
`default_nettype none

package fcca_pkg;

  localparam int OP_W   = 2;
  localparam int SIZE_W = 22;
  localparam int STAT_W = 2;

  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BAD_START = 2'd2;

endpackage

`default_nettype wire

// ===== hdl/fat_cluster_chain_allocator_core.sv =====
// Top level of the cluster chain allocator: link table memory, free count and sequencer.
//
//   channel   ports                                   handshake
//   -------   -------------------------------------   --------------------------------
//   command   in_operation, in_size_bytes,             word taken when start is high
//             in_start_cluster                         and busy is low
//   result    out_status, out_has_chain,               word shown for one cycle while
//             out_first_cluster, out_entry_value       out_valid is high, always taken
//
// After reset the block sweeps the link table once, one entry per cycle, writing the
// end mark into the two reserved entries and zero everywhere else; busy stays high
// until the sweep is done.
// A read passes through S_RDAT. A zero-size allocate answers from idle; any other
// passes through S_AMUL and S_ACHK, and one that is not rejected then scans the table
// first-fit up to the highest cluster it links, one table entry per cycle through the
// single read port, and ends in S_AFIN. A free walks the chain through S_FDAT and
// S_FRD, reading each link and clearing its entry; the walk also ends on an entry
// that is already free.
// A bad start cluster, an out of range read and an unknown operation answer from idle.
// The result word comes out of registers in the cycle after the sequencer's last state,
// and the receiver cannot stall it; a new command word may be taken in that same cycle.
`default_nettype none

module fat_cluster_chain_allocator_core
  import fcca_pkg::*;
#(
  parameter int TABLE_ENTRIES = 4096,
  parameter int CLUSTER_BYTES = 512
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [OP_W-1:0]                  in_operation,
  input  wire logic [SIZE_W-1:0]                in_size_bytes,
  input  wire logic [$clog2(TABLE_ENTRIES)-1:0] in_start_cluster,
  output logic                                  out_valid,
  output logic [STAT_W-1:0]                     out_status,
  output logic                                  out_has_chain,
  output logic [$clog2(TABLE_ENTRIES)-1:0]      out_first_cluster,
  output logic [$clog2(TABLE_ENTRIES)-1:0]      out_entry_value
);

  // Cluster number width, and the free count width, which must hold TABLE_ENTRIES.
  localparam int CW  = $clog2(TABLE_ENTRIES);
  localparam int FW  = CW + 1;
  localparam int CBW = $clog2(CLUSTER_BYTES + 1);
  localparam int PW  = FW + CBW;
  localparam int MW  = (PW > SIZE_W) ? PW : SIZE_W;

  localparam logic [CW-1:0]     END_MARK  = CW'(TABLE_ENTRIES - 1);
  localparam logic [FW-1:0]     N_EXT     = FW'(TABLE_ENTRIES);
  localparam logic [FW-1:0]     LAST_EXT  = FW'(TABLE_ENTRIES - 1);
  localparam logic [FW-1:0]     FREE_INIT = FW'(TABLE_ENTRIES - 2);
  localparam logic [SIZE_W-1:0] CB_SZ     = SIZE_W'(CLUSTER_BYTES);
  localparam logic [MW-1:0]     CB_MW     = MW'(CLUSTER_BYTES);

  // Sequencer states.
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLEAR = 4'd1;
  localparam logic [3:0] S_AMUL  = 4'd2;
  localparam logic [3:0] S_ACHK  = 4'd3;
  localparam logic [3:0] S_ASCAN = 4'd4;
  localparam logic [3:0] S_AFIN  = 4'd5;
  localparam logic [3:0] S_FRD   = 4'd6;
  localparam logic [3:0] S_FDAT  = 4'd7;
  localparam logic [3:0] S_RDAT  = 4'd8;

  // A cluster may be allocated or freed only if it is neither entry 0 nor the last.
  function automatic logic usable(input logic [CW-1:0] c);
    usable = (c != '0) && ({1'b0, c} < LAST_EXT);
  endfunction

  // Link table: one write port and one registered read port.
  logic [CW-1:0] link_mem [TABLE_ENTRIES];
  logic          mem_we;
  logic [CW-1:0] mem_waddr;
  logic [CW-1:0] mem_wdata;
  logic [CW-1:0] mem_raddr;
  logic [CW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= link_mem[mem_raddr];
  end

  logic [3:0]        state_r, state_nxt;
  logic [CW-1:0]     clr_r, clr_nxt;
  logic [FW-1:0]     free_r, free_nxt;
  logic [SIZE_W-1:0] rem_r, rem_nxt;
  logic [MW-1:0]     prod_r, prod_nxt;
  logic [CW-1:0]     cur_r, cur_nxt;
  logic [CW-1:0]     scan_r, scan_nxt;
  logic [CW-1:0]     addr_r, addr_nxt;
  logic              rv_r, rv_nxt;
  logic              first_r, first_nxt;
  logic [CW-1:0]     first_cl_r, first_cl_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_status_r, out_status_nxt;
  logic              out_has_chain_r, out_has_chain_nxt;
  logic [CW-1:0]     out_first_cluster_r, out_first_cluster_nxt;
  logic [CW-1:0]     out_entry_value_r, out_entry_value_nxt;

  always_comb begin
    state_nxt             = state_r;
    clr_nxt               = clr_r;
    free_nxt              = free_r;
    rem_nxt               = rem_r;
    prod_nxt              = prod_r;
    cur_nxt               = cur_r;
    scan_nxt              = scan_r;
    addr_nxt              = addr_r;
    rv_nxt                = rv_r;
    first_nxt             = first_r;
    first_cl_nxt          = first_cl_r;
    out_valid_nxt         = 1'b0;
    out_status_nxt        = out_status_r;
    out_has_chain_nxt     = out_has_chain_r;
    out_first_cluster_nxt = out_first_cluster_r;
    out_entry_value_nxt   = out_entry_value_r;
    mem_we                = 1'b0;
    mem_waddr             = cur_r;
    mem_wdata             = '0;
    mem_raddr             = cur_r;

    case (state_r)
      S_CLEAR: begin
        // Reserved entries get the end mark, every other entry reads as free.
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = (clr_r == '0 || clr_r == END_MARK) ? END_MARK : '0;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == END_MARK) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          // Default result word; each path overrides what it reports.
          out_status_nxt        = STAT_OK;
          out_has_chain_nxt     = 1'b0;
          out_first_cluster_nxt = '0;
          out_entry_value_nxt   = '0;
          case (in_operation)
            OP_ALLOC: begin
              rem_nxt = in_size_bytes;
              if (in_size_bytes == '0) begin
                out_valid_nxt = 1'b1;
              end else begin
                state_nxt = S_AMUL;
              end
            end
            OP_FREE: begin
              cur_nxt   = in_start_cluster;
              first_nxt = 1'b1;
              mem_raddr = in_start_cluster;
              if (usable(in_start_cluster)) begin
                state_nxt = S_FDAT;
              end else begin
                out_status_nxt = STAT_BAD_START;
                out_valid_nxt  = 1'b1;
              end
            end
            OP_READ: begin
              mem_raddr = in_start_cluster;
              if ({1'b0, in_start_cluster} < N_EXT) begin
                state_nxt = S_RDAT;
              end else begin
                out_status_nxt = STAT_BAD_START;
                out_valid_nxt  = 1'b1;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      S_AMUL: begin
        // Capacity in bytes of the clusters still free.
        prod_nxt  = MW'(free_r) * CB_MW;
        state_nxt = S_ACHK;
      end

      S_ACHK: begin
        // ceil(size / CLUSTER_BYTES) exceeds the free count exactly when size exceeds
        // the free capacity in bytes.
        if (MW'(rem_r) > prod_r) begin
          out_status_nxt = STAT_FULL;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          scan_nxt  = CW'(1);
          rv_nxt    = 1'b0;
          first_nxt = 1'b1;
          state_nxt = S_ASCAN;
        end
      end

      S_ASCAN: begin
        // One read issued per cycle; the word read the cycle before is examined here.
        mem_raddr = scan_r;
        scan_nxt  = scan_r + 1'b1;
        addr_nxt  = scan_r;
        rv_nxt    = 1'b1;
        if (rv_r && rd_data_r == '0) begin
          free_nxt = free_r - 1'b1;
          if (first_r) begin
            first_cl_nxt = addr_r;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = cur_r;
            mem_wdata = addr_r;
          end
          first_nxt = 1'b0;
          cur_nxt   = addr_r;
          if (rem_r <= CB_SZ) begin
            state_nxt = S_AFIN;
          end else begin
            rem_nxt = rem_r - CB_SZ;
          end
        end
      end

      S_AFIN: begin
        mem_we                = 1'b1;
        mem_waddr             = cur_r;
        mem_wdata             = END_MARK;
        out_has_chain_nxt     = 1'b1;
        out_first_cluster_nxt = first_cl_r;
        out_valid_nxt         = 1'b1;
        state_nxt             = S_IDLE;
      end

      S_FRD: begin
        mem_raddr = cur_r;
        state_nxt = S_FDAT;
      end

      S_FDAT: begin
        // A free entry ends the walk; at the chain start it means a bad request.
        // Revisiting a cleared cluster reads zero, so a looped chain ends too.
        if (rd_data_r == '0) begin
          if (first_r) begin
            out_status_nxt = STAT_BAD_START;
          end
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = cur_r;
          mem_wdata = '0;
          free_nxt  = free_r + 1'b1;
          first_nxt = 1'b0;
          if (!usable(rd_data_r)) begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            cur_nxt   = rd_data_r;
            state_nxt = S_FRD;
          end
        end
      end

      S_RDAT: begin
        out_entry_value_nxt = rd_data_r;
        out_valid_nxt       = 1'b1;
        state_nxt           = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      free_r      <= FREE_INIT;
      rv_r        <= 1'b0;
      first_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      free_r      <= free_nxt;
      rv_r        <= rv_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r               <= rem_nxt;
    prod_r              <= prod_nxt;
    cur_r               <= cur_nxt;
    scan_r              <= scan_nxt;
    addr_r              <= addr_nxt;
    first_cl_r          <= first_cl_nxt;
    out_status_r        <= out_status_nxt;
    out_has_chain_r     <= out_has_chain_nxt;
    out_first_cluster_r <= out_first_cluster_nxt;
    out_entry_value_r   <= out_entry_value_nxt;
  end

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_has_chain     = out_has_chain_r;
  assign out_first_cluster = out_first_cluster_r;
  assign out_entry_value   = out_entry_value_r;

endmodule

`default_nettype wire

// ===== hdl/fcca_checker.sv =====
// Port-level checker for the cluster chain allocator, bound to its top level.
`default_nettype none

module fcca_checker
  import fcca_pkg::*;
#(
  parameter int CW = 12
) (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              out_valid,
  input wire logic [STAT_W-1:0] out_status,
  input wire logic              out_has_chain,
  input wire logic [CW-1:0]     out_first_cluster
);

  // Reset always starts the table clearing sweep.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("block not busy after reset");

  // A taken word either starts work or answers at once.
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted word neither started nor answered");

  // A result is only shown once the sequencer is back to idle.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // A result with a failing status reports no chain.
  a_full_no_chain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != STAT_OK) |-> (!out_has_chain && out_first_cluster == '0))
    else $error("chain reported with a failing status");

endmodule

bind fat_cluster_chain_allocator_core fcca_checker #(
  .CW($clog2(TABLE_ENTRIES))
) u_fcca_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_status       (out_status),
  .out_has_chain    (out_has_chain),
  .out_first_cluster(out_first_cluster)
);

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the cluster chain allocator: directed command table, then random traffic.
module tb_top
  import fcca_pkg::*;
();

  localparam int TABLE_ENTRIES = 4096;
  localparam int CLUSTER_BYTES = 512;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] END_LINK = '1;
  // The operation field has one code the block does not define; it must answer all zeros.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_WORDS = 113;
  localparam int DRAIN_CYCLES = 16;
  // The slowest legal word is a free of a full-table chain; the limit also covers the
  // clearing sweep after reset, long idle gaps and ~140 words, with room to spare.
  localparam longint CYCLE_LIMIT = 5_000_000;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              has_chain;
    logic [IDX_W-1:0]  first_cluster;
    logic [IDX_W-1:0]  entry_value;
  } reply_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [SIZE_W-1:0] size;
    logic [IDX_W-1:0]  cluster;
    logic              known;   // the reply is typed into the table
    reply_t            reply;
  } cmd_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [OP_W-1:0]   in_operation = '0;
  logic [SIZE_W-1:0] in_size_bytes = '0;
  logic [IDX_W-1:0]  in_start_cluster = '0;
  logic              out_valid;
  logic [STAT_W-1:0] out_status;
  logic              out_has_chain;
  logic [IDX_W-1:0]  out_first_cluster;
  logic [IDX_W-1:0]  out_entry_value;

  // Private copy of the allocator state, advanced once per accepted command word.
  logic [IDX_W-1:0] link_mem [TABLE_ENTRIES];
  int               free_cnt;

  reply_t           expected_replies[$];
  logic [IDX_W-1:0] chain_heads[$];     // first clusters of chains believed to be live
  cmd_row_t         dir_rows[$];
  int               fails = 0;
  int               calm_left = 0;      // words left in a stretch without idle gaps
  longint           cycles = 0;

  always #4 clk = ~clk;

  fat_cluster_chain_allocator_core uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_size_bytes    (in_size_bytes),
    .in_start_cluster (in_start_cluster),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_has_chain    (out_has_chain),
    .out_first_cluster(out_first_cluster),
    .out_entry_value  (out_entry_value)
  );

  // Clusters 0 and the last one are reserved and can never sit on a chain.
  function automatic bit usable(int c);
    return c != 0 && c < TABLE_ENTRIES - 1;
  endfunction

  // First-fit search: lowest free, non-reserved cluster at or above the given one.
  function automatic int first_free_from(int from);
    for (int c = from; c < TABLE_ENTRIES - 1; c++) begin
      if (c != 0 && link_mem[c] == '0) return c;
    end
    return 0;
  endfunction

  // Works out the reply to one command word and updates the private table copy.
  function automatic reply_t predict_reply(logic [OP_W-1:0] op, logic [SIZE_W-1:0] size,
                                           logic [IDX_W-1:0] cluster);
    reply_t r;
    int     need;
    int     cur;
    int     nxt;
    int     steps;
    r = '0;
    case (op)
      OP_ALLOC: begin
        need = (int'(size) + CLUSTER_BYTES - 1) / CLUSTER_BYTES;
        if (need != 0) begin
          // A request that does not fit is refused before anything is written.
          if (need > free_cnt) begin
            r.status = STAT_FULL;
          end else begin
            cur = first_free_from(1);
            r.first_cluster = IDX_W'(cur);
            for (int k = 1; k < need; k++) begin
              nxt = first_free_from(cur + 1);
              link_mem[cur] = IDX_W'(nxt);
              cur = nxt;
            end
            link_mem[cur] = END_LINK;
            free_cnt -= need;
            r.has_chain = 1'b1;
          end
        end
      end
      OP_FREE: begin
        if (!usable(cluster) || link_mem[cluster] == '0) begin
          r.status = STAT_BAD_START;
        end else begin
          // The walk stops at an end mark, at a reserved or already free cluster,
          // or after a full table's worth of steps on a looped chain.
          cur = cluster;
          steps = 0;
          while (steps < TABLE_ENTRIES && usable(cur) && link_mem[cur] != '0) begin
            nxt = link_mem[cur];
            link_mem[cur] = '0;
            free_cnt++;
            steps++;
            if (nxt == END_LINK) break;
            cur = nxt;
          end
        end
      end
      OP_READ: begin
        // A 12-bit index is always inside the table, so there is no range error here.
        r.entry_value = link_mem[cluster];
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic cmd_row_t cmd(logic [OP_W-1:0] op, int size, int cluster);
    cmd_row_t c;
    c = '0;
    c.op = op;
    c.size = SIZE_W'(size);
    c.cluster = IDX_W'(cluster);
    return c;
  endfunction

  function automatic cmd_row_t cmd_known(logic [OP_W-1:0] op, int size, int cluster,
                                         logic [STAT_W-1:0] status, bit has_chain,
                                         int first, int value);
    cmd_row_t c;
    c = cmd(op, size, cluster);
    c.known = 1'b1;
    c.reply.status = status;
    c.reply.has_chain = has_chain;
    c.reply.first_cluster = IDX_W'(first);
    c.reply.entry_value = IDX_W'(value);
    return c;
  endfunction

  // Appends one row to the directed table.
  function automatic void add_row(cmd_row_t row);
    dir_rows = {dir_rows, row};
  endfunction

  // Presents one command word after a random idle gap and holds it until the block
  // takes it. Inputs move on the falling edge; busy is sampled on the rising edge.
  task automatic send_cmd(input cmd_row_t row);
    int     gap;
    reply_t pred;
    if (calm_left > 0) begin
      calm_left--;
      gap = 0;
    end else if ($urandom_range(0, 19) == 0) begin
      calm_left = $urandom_range(8, 16);
      gap = 0;
    end else if ($urandom_range(0, 9) == 0) begin
      gap = $urandom_range(20, 60);
    end else begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 3);
    end
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start            <= 1'b1;
    in_operation     <= row.op;
    in_size_bytes    <= row.size;
    in_start_cluster <= row.cluster;
    do @(posedge clk); while (busy);
    pred = predict_reply(row.op, row.size, row.cluster);
    expected_replies = {expected_replies, (row.known ? row.reply : pred)};
    if (pred.has_chain) chain_heads = {chain_heads, pred.first_cluster};
  endtask

  // Random traffic. Most words allocate and later free well-formed chains and read
  // entries on them; the rest are stray frees and unused codes, and some allocations are oversized.
  task automatic run_random();
    cmd_row_t c;
    int       pick;
    int       s;
    int       idx;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      c = '0;
      // Fields an operation ignores still carry random bits.
      c.size = SIZE_W'($urandom);
      c.cluster = IDX_W'($urandom);
      pick = $urandom_range(0, 99);
      // Keep the table lightly loaded so first-fit scans stay short.
      if (chain_heads.size() > 12 && pick < 40) pick = 50;
      if (pick >= 40 && pick < 70 && chain_heads.size() == 0) pick = 0;
      if (pick < 40) begin
        c.op = OP_ALLOC;
        s = $urandom_range(0, 99);
        if (s < 5) c.size = '0;
        else if (s < 12) c.size = SIZE_W'($urandom);
        else if (s < 20) c.size = SIZE_W'($urandom_range(1, 64 * CLUSTER_BYTES));
        else c.size = SIZE_W'($urandom_range(1, 8 * CLUSTER_BYTES));
      end else if (pick < 70) begin
        c.op = OP_FREE;
        idx = $urandom_range(0, chain_heads.size() - 1);
        c.cluster = chain_heads[idx];
        chain_heads.delete(idx);
      end else if (pick < 88) begin
        c.op = OP_READ;
        if (chain_heads.size() != 0 && $urandom_range(0, 1) == 1) begin
          idx = $urandom_range(0, chain_heads.size() - 1);
          c.cluster = chain_heads[idx] + IDX_W'($urandom_range(0, 3));
        end
      end else begin
        c.op = ($urandom_range(0, 1) == 1) ? OP_FREE : OP_UNUSED;
      end
      send_cmd(c);
    end
  endtask

  // Every result word is compared with the oldest outstanding expectation.
  always @(posedge clk) begin : check_replies
    reply_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (expected_replies.size() == 0) begin
        $error("result word with no command word outstanding");
        fails++;
      end else begin
        want = expected_replies.pop_front();
        if (out_status !== want.status) begin
          $error("out_status: expected %0d, got %0d", want.status, out_status);
          fails++;
        end
        if (out_has_chain !== want.has_chain) begin
          $error("out_has_chain: expected %0d, got %0d", want.has_chain, out_has_chain);
          fails++;
        end
        if (out_first_cluster !== want.first_cluster) begin
          $error("out_first_cluster: expected %0d, got %0d",
                 want.first_cluster, out_first_cluster);
          fails++;
        end
        if (out_entry_value !== want.entry_value) begin
          $error("out_entry_value: expected %0d, got %0d", want.entry_value, out_entry_value);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < TABLE_ENTRIES; i++) link_mem[i] = '0;
    link_mem[0] = END_LINK;
    link_mem[TABLE_ENTRIES-1] = END_LINK;
    free_cnt = TABLE_ENTRIES - 2;

    // Reserved entries, a free entry, and frees that must be refused.
    add_row(cmd_known(OP_READ, 0, 0, STAT_OK, 0, 0, 4095));
    add_row(cmd_known(OP_READ, 4194303, 4095, STAT_OK, 0, 0, 4095));
    add_row(cmd_known(OP_READ, 0, 1, STAT_OK, 0, 0, 0));
    add_row(cmd_known(OP_FREE, 0, 0, STAT_BAD_START, 0, 0, 0));
    add_row(cmd_known(OP_FREE, 0, 4095, STAT_BAD_START, 0, 0, 0));
    add_row(cmd_known(OP_FREE, 0, 5, STAT_BAD_START, 0, 0, 0));
    // Zero size builds nothing; sizes beyond the free count are refused.
    add_row(cmd_known(OP_ALLOC, 0, 4095, STAT_OK, 0, 0, 0));
    add_row(cmd_known(OP_ALLOC, 4194303, 0, STAT_FULL, 0, 0, 0));
    add_row(cmd_known(OP_ALLOC, 2097152, 0, STAT_FULL, 0, 0, 0));
    add_row(cmd_known(OP_ALLOC, 4094 * 512 + 1, 0, STAT_FULL, 0, 0, 0));
    // Small chains at the bottom of the table, and the rounding of partial clusters.
    add_row(cmd_known(OP_ALLOC, 1, 0, STAT_OK, 1, 1, 0));
    add_row(cmd_known(OP_ALLOC, 512, 0, STAT_OK, 1, 2, 0));
    add_row(cmd_known(OP_ALLOC, 513, 0, STAT_OK, 1, 3, 0));
    add_row(cmd_known(OP_READ, 0, 3, STAT_OK, 0, 0, 4));
    add_row(cmd_known(OP_READ, 0, 4, STAT_OK, 0, 0, 4095));
    // Free a hole and refill it: the new chain must skip the clusters still in use.
    add_row(cmd(OP_FREE, 0, 2));
    add_row(cmd(OP_ALLOC, 1024, 0));
    add_row(cmd(OP_READ, 0, 2));
    add_row(cmd_known(OP_UNUSED, 4194303, 4095, STAT_OK, 0, 0, 0));
    // Clearing the tail first leaves a broken chain for the next free to stop on.
    add_row(cmd(OP_FREE, 0, 5));
    add_row(cmd(OP_FREE, 0, 2));
    add_row(cmd(OP_FREE, 0, 1));
    add_row(cmd(OP_FREE, 0, 3));
    // With the table empty again, one chain takes every usable cluster.
    add_row(cmd_known(OP_ALLOC, 4094 * 512, 0, STAT_OK, 1, 1, 0));
    add_row(cmd_known(OP_ALLOC, 1, 0, STAT_FULL, 0, 0, 0));
    add_row(cmd_known(OP_READ, 0, 4094, STAT_OK, 0, 0, 4095));
    add_row(cmd(OP_FREE, 0, 1));

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // The block sweeps its table after reset with busy high; send_cmd waits it out.
    foreach (dir_rows[i]) send_cmd(dir_rows[i]);
    chain_heads.delete();
    run_random();

    @(negedge clk);
    start <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
